### src/boca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package boca_pkg;

  // Default sizes of the class table and of the box signature.
  localparam int unsigned MaxClassesDef = 256;
  localparam int unsigned MaxBoxesDef   = 8;

  // Fixed field widths.
  localparam int unsigned StateW  = 32;
  localparam int unsigned CfgW    = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CountW  = 6;
  localparam int unsigned ClsOutW = 8;
  localparam int unsigned SigOutW = 48;
  localparam int unsigned ItemW   = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgLatticeLen = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBoxSize    = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] LatticeLenRst = 6'd32;
  localparam logic [CfgW-1:0] BoxSizeRst    = 6'd4;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t StatExist   = 2'd0;
  localparam status_t StatNew     = 2'd1;
  localparam status_t StatFull    = 2'd2;
  localparam status_t StatTooMany = 2'd3;

  // Status of the signature builder towards the controller.
  typedef struct packed {
    logic done;
    logic too_many;
  } sig_stat_t;

  // Status of the class table towards the controller.
  typedef struct packed {
    logic    done;
    status_t status;
  } tbl_stat_t;

endpackage

`default_nettype wire

### src/boca_sig_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module boca_sig_unit #(
  parameter int unsigned MaxBoxes = boca_pkg::MaxBoxesDef
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [boca_pkg::StateW-1:0]            word_i,
  input  wire logic [boca_pkg::CfgW-1:0]              lattice_len_i,
  input  wire logic [boca_pkg::CfgW-1:0]              box_size_i,
  output logic      [boca_pkg::CountW*MaxBoxes-1:0]   sig_o,
  output boca_pkg::sig_stat_t                         stat_o
);
  import boca_pkg::*;

  localparam int unsigned SigW = CountW * MaxBoxes;
  localparam int unsigned IdxW = $clog2(MaxBoxes + 1);
  localparam int unsigned PosW = CfgW + 1;

  logic              busy_q;
  logic [StateW-1:0] word_q;
  logic [PosW-1:0]   pos_q;
  logic [IdxW-1:0]   idx_q;
  logic [SigW-1:0]   sig_q, sig_d;

  logic [PosW-1:0]   box_end;
  logic              fits;
  logic              last;
  logic [StateW-1:0] box_mask;
  logic [StateW-1:0] box_bits;
  logic [CountW-1:0] ones;
  logic              finish;

  // One box per cycle: bounds check, shift, mask and population count.
  always_comb begin
    box_end  = pos_q + {1'b0, box_size_i};
    fits     = (box_size_i != '0) && (box_end <= {1'b0, lattice_len_i});
    last     = (idx_q == IdxW'(MaxBoxes));
    box_mask = ~({StateW{1'b1}} << box_size_i);
    box_bits = (word_q >> pos_q) & box_mask;
    ones     = CountW'($countones(box_bits));
    finish   = busy_q && (!fits || last);
  end

  // Place the count of the current box into its lane of the signature.
  always_comb begin
    sig_d = sig_q;
    for (int b = 0; b < MaxBoxes; b++) begin
      if (idx_q == IdxW'(b)) begin
        sig_d[b*CountW +: CountW] = ones;
      end
    end
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (finish) begin
      busy_q <= 1'b0;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      word_q <= word_i;
      pos_q  <= '0;
      idx_q  <= '0;
      sig_q  <= '0;
    end else if (busy_q && !finish) begin
      pos_q <= box_end;
      idx_q <= idx_q + 1'b1;
      sig_q <= sig_d;
    end
  end

  assign sig_o           = sig_q;
  assign stat_o.done     = finish;
  assign stat_o.too_many = busy_q && fits && last;

`ifndef SYNTHESIS
  // The box index never passes the box limit while the unit works.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= IdxW'(MaxBoxes))
    else $error("box index beyond limit");

  // A finished pass leaves the unit idle unless a new item starts.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && !start_i) |=> !busy_q)
    else $error("unit still busy after finishing");

  // A too-many-boxes verdict only comes with the end of a pass.
  a_too_many_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.too_many |-> stat_o.done)
    else $error("too many boxes without done");
`endif

endmodule

`default_nettype wire

### src/boca_class_table.sv
`timescale 1ns / 1ps
`default_nettype none

module boca_class_table #(
  parameter int unsigned MaxClasses = boca_pkg::MaxClassesDef,
  parameter int unsigned MaxBoxes   = boca_pkg::MaxBoxesDef
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 clr_i,
  input  wire logic                                 start_i,
  input  wire logic [boca_pkg::CountW*MaxBoxes-1:0] sig_i,
  output logic      [$clog2(MaxClasses)-1:0]        cls_o,
  output boca_pkg::tbl_stat_t                       stat_o
);
  import boca_pkg::*;

  localparam int unsigned SigW  = CountW * MaxBoxes;
  localparam int unsigned AddrW = $clog2(MaxClasses);
  localparam int unsigned CntW  = $clog2(MaxClasses + 1);

  logic [SigW-1:0]  sig_mem [MaxClasses];

  logic             busy_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  ptr_q;
  logic             pend_q;
  logic [AddrW-1:0] cmp_q;
  logic [SigW-1:0]  rdata_q;
  logic [SigW-1:0]  sig_q;

  logic hit, scan_end, room, rd_en, wr_en;

  // Linear search: one read issued and one entry compared in each cycle.
  always_comb begin
    hit      = busy_q && pend_q && (rdata_q == sig_q);
    scan_end = busy_q && !hit && (ptr_q == count_q);
    room     = (count_q != CntW'(MaxClasses));
    rd_en    = busy_q && !hit && !scan_end;
    wr_en    = scan_end && room;
  end

  // Verdict of the search.
  always_comb begin
    stat_o.done = hit || scan_end;
    if (hit) begin
      stat_o.status = StatExist;
      cls_o         = cmp_q;
    end else if (room) begin
      stat_o.status = StatNew;
      cls_o         = count_q[AddrW-1:0];
    end else begin
      stat_o.status = StatFull;
      cls_o         = '0;
    end
  end

  // Search control and class count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (stat_o.done) begin
        busy_q <= 1'b0;
      end
      if (clr_i) begin
        count_q <= '0;
      end else if (wr_en) begin
        count_q <= count_q + 1'b1;
      end
      if (start_i) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
      end else if (rd_en) begin
        ptr_q  <= ptr_q + 1'b1;
        pend_q <= 1'b1;
      end
    end
  end

  // Item payload and compare address.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sig_q <= sig_i;
    end
    if (rd_en) begin
      cmp_q <= ptr_q[AddrW-1:0];
    end
  end

  // Signature store: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sig_mem[count_q[AddrW-1:0]] <= sig_q;
    end
    if (rd_en) begin
      rdata_q <= sig_mem[ptr_q[AddrW-1:0]];
    end
  end

`ifndef SYNTHESIS
  // The class count never exceeds the table size.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxClasses))
    else $error("class count beyond table size");

  // A new class grows the count by exactly one.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && !clr_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("class count did not advance");

  // A match only ever comes from a stored entry.
  a_hit_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> CntW'(cmp_q) < count_q)
    else $error("match outside stored classes");
`endif

endmodule

`default_nettype wire

### src/box_occupancy_class_assigner.sv
`timescale 1ns / 1ps
`default_nettype none

// Box occupancy class assigner.
// Input channel (in_valid_i / in_stall_o) carries one occupation word and a
// restart flag per item; the output channel (out_valid_o / out_stall_i) gives
// one result per item: class number, status, packed box signature and the
// running item index. Configuration writes (cfg_valid_i / cfg_ready_o) set the
// lattice length (index 0) and the box size (index 1); they are taken at once
// and are meant to happen while the block is idle.
// One item is handled at a time. It passes through the signature builder (one
// box per cycle through the shared shift and population count), then the class
// search (one table read and one compare per cycle), then moves the result into
// the output register; the next item is taken only after that. An item with too
// many boxes skips the search.
// in_stall_o stays high from acceptance until the result has been moved into
// the output register. A stalled result holds in the output register while
// the next item is already being worked on.
// Reset clears the item counter and the class count and restores the
// configuration defaults; the signature table needs no clearing.

module box_occupancy_class_assigner #(
  parameter int unsigned MaxClasses = boca_pkg::MaxClassesDef,
  parameter int unsigned MaxBoxes   = boca_pkg::MaxBoxesDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input items.
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [boca_pkg::StateW-1:0]    state_word_i,
  input  wire logic                           restart_i,
  // Result items.
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [boca_pkg::ClsOutW-1:0]   class_index_o,
  output boca_pkg::status_t                   status_o,
  output logic      [boca_pkg::SigOutW-1:0]   signature_o,
  output logic      [boca_pkg::ItemW-1:0]     item_index_o,
  // Configuration writes.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [boca_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [boca_pkg::CfgW-1:0]      cfg_data_i
);
  import boca_pkg::*;

  localparam int unsigned SigW  = CountW * MaxBoxes;
  localparam int unsigned AddrW = $clog2(MaxClasses);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SSig  = 2'd1;
  localparam logic [1:0] STbl  = 2'd2;
  localparam logic [1:0] SOut  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CfgW-1:0]   lattice_len_q;
  logic [CfgW-1:0]   box_size_q;
  logic [ItemW-1:0]  item_cnt_q;

  logic [ClsOutW-1:0] res_cls_q;
  status_t            res_status_q;
  logic [SigOutW-1:0] res_sig_q;
  logic [ItemW-1:0]   res_idx_q;

  logic               out_valid_q;
  logic [ClsOutW-1:0] out_cls_q;
  status_t            out_status_q;
  logic [SigOutW-1:0] out_sig_q;
  logic [ItemW-1:0]   out_idx_q;

  logic              accept;
  logic              tbl_start;
  logic              out_load;
  logic [SigW-1:0]   sig;
  sig_stat_t         sig_stat;
  logic [AddrW-1:0]  tbl_cls;
  tbl_stat_t         tbl_stat;

  logic [SigW+SigOutW-1:0]    sig_ext;
  logic [AddrW+ClsOutW-1:0]   cls_ext;
  logic [ItemW-1:0]           item_base;

  // Handshake and sequencing decisions.
  always_comb begin
    accept    = in_valid_i && (state_q == SIdle);
    tbl_start = (state_q == SSig) && sig_stat.done && !sig_stat.too_many;
    out_load  = (state_q == SOut) && (!out_valid_q || !out_stall_i);
    item_base = restart_i ? '0 : item_cnt_q;
    sig_ext   = {{SigOutW{1'b0}}, sig};
    cls_ext   = {{ClsOutW{1'b0}}, tbl_cls};
  end

  // Controller next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (accept) state_d = SSig;
      SSig: begin
        if (sig_stat.done) begin
          state_d = sig_stat.too_many ? SOut : STbl;
        end
      end
      STbl: if (tbl_stat.done) state_d = SOut;
      SOut: if (out_load) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      lattice_len_q <= LatticeLenRst;
      box_size_q    <= BoxSizeRst;
      item_cnt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && (cfg_index_i == CfgLatticeLen)) begin
        lattice_len_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == CfgBoxSize)) begin
        box_size_q <= cfg_data_i;
      end
      if (accept) begin
        item_cnt_q <= item_base + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result being assembled for the current item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_idx_q <= item_base;
    end
    if ((state_q == SSig) && sig_stat.done) begin
      if (sig_stat.too_many) begin
        res_cls_q    <= '0;
        res_status_q <= StatTooMany;
        res_sig_q    <= '0;
      end else begin
        res_sig_q <= sig_ext[SigOutW-1:0];
      end
    end
    if ((state_q == STbl) && tbl_stat.done) begin
      res_cls_q    <= cls_ext[ClsOutW-1:0];
      res_status_q <= tbl_stat.status;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cls_q    <= res_cls_q;
      out_status_q <= res_status_q;
      out_sig_q    <= res_sig_q;
      out_idx_q    <= res_idx_q;
    end
  end

  boca_sig_unit #(
    .MaxBoxes(MaxBoxes)
  ) u_sig_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .word_i       (state_word_i),
    .lattice_len_i(lattice_len_q),
    .box_size_i   (box_size_q),
    .sig_o        (sig),
    .stat_o       (sig_stat)
  );

  boca_class_table #(
    .MaxClasses(MaxClasses),
    .MaxBoxes  (MaxBoxes)
  ) u_class_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (accept && restart_i),
    .start_i(tbl_start),
    .sig_i  (sig),
    .cls_o  (tbl_cls),
    .stat_o (tbl_stat)
  );

  assign in_stall_o    = (state_q != SIdle);
  assign out_valid_o   = out_valid_q;
  assign class_index_o = out_cls_q;
  assign status_o      = out_status_q;
  assign signature_o   = out_sig_q;
  assign item_index_o  = out_idx_q;
  assign cfg_ready_o   = 1'b1;

`ifndef SYNTHESIS
  // The signature builder only reports while the controller waits for it.
  a_sig_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sig_stat.done |-> state_q == SSig)
    else $error("signature done outside its phase");

  // The class search only reports while the controller waits for it.
  a_tbl_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_stat.done |-> state_q == STbl)
    else $error("search done outside its phase");

  // A too-many-boxes result carries neither class nor signature.
  a_too_many_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == StatTooMany)) |->
      (signature_o == '0) && (class_index_o == '0))
    else $error("too many boxes result not cleared");

  // Loading the output never overwrites a result still held by a stall.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire
